// ===== src/accumulator_cpu_8bit_macros.svh =====
// Assertion macros shared by the checker of the accumulator CPU.
// No dependencies; included by the files that assert.
`ifndef ACCUMULATOR_CPU_8BIT_MACROS_SVH
`define ACCUMULATOR_CPU_8BIT_MACROS_SVH

// Same-cycle implication, inactive while reset is high.
`define ACCU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define ACCU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/accu_pkg.sv =====
// Types, codes and microcode ROM of the accumulator CPU.
// No dependencies; used by the sequencer, the top level, the checker and the testbench.
package accu_pkg;

   localparam int MEM_DEPTH = 256;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int DATA_W    = 8;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_EXEC  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef logic [3:0] opcode_type;

   localparam opcode_type OP_STA = 4'h1;
   localparam opcode_type OP_LDA = 4'h2;
   localparam opcode_type OP_ADD = 4'h3;
   localparam opcode_type OP_OR  = 4'h4;
   localparam opcode_type OP_AND = 4'h5;
   localparam opcode_type OP_NOT = 4'h6;
   localparam opcode_type OP_JMP = 4'h8;
   localparam opcode_type OP_JN  = 4'h9;
   localparam opcode_type OP_JZ  = 4'hA;
   localparam opcode_type OP_HLT = 4'hF;

   typedef logic [3:0] ustep_type;

   localparam ustep_type US_IDLE  = 4'd0;
   localparam ustep_type US_WR    = 4'd1;
   localparam ustep_type US_RD    = 4'd2;
   localparam ustep_type US_RDCAP = 4'd3;
   localparam ustep_type US_EX0   = 4'd4;
   localparam ustep_type US_EX1   = 4'd5;
   localparam ustep_type US_EX2   = 4'd6;
   localparam ustep_type US_EX3   = 4'd7;
   localparam ustep_type US_EX4   = 4'd8;
   localparam ustep_type US_RST   = 4'd9;
   localparam ustep_type US_DONE  = 4'd10;

   // Memory address source.
   typedef enum logic [1:0] {
      AS_REQ  = 2'd0,
      AS_PC   = 2'd1,
      AS_PC1  = 2'd2,
      AS_OPND = 2'd3
   } asel_type;

   // Sequencing of the step counter.
   typedef enum logic [2:0] {
      SQ_NEXT = 3'd0,
      SQ_JUMP = 3'd1,
      SQ_CMD  = 3'd2,
      SQ_HALT = 3'd3,
      SQ_OUT  = 3'd4
   } seq_type;

   typedef struct packed {
      asel_type  asel;
      logic      take_req;
      logic      mem_wr_req;
      logic      mem_wr_sta;
      logic      ld_opc;
      logic      ld_opnd;
      logic      ld_rdata;
      logic      exec;
      logic      clr_cpu;
      logic      emit;
      seq_type   seq;
      ustep_type target;
   } ucode_type;

   typedef struct packed {
      logic    req_fire;
      cmd_type cmd;
      logic    halted;
      logic    out_free;
   } seq_status_type;

   function automatic ucode_type ucode(input ustep_type step);
      ucode_type cw;
      cw        = '0;
      cw.asel   = AS_REQ;
      cw.seq    = SQ_NEXT;
      cw.target = US_IDLE;
      unique case (step)
         US_IDLE: begin
            cw.take_req = 1'b1;
            cw.seq      = SQ_CMD;
         end
         US_WR: begin
            cw.mem_wr_req = 1'b1;
            cw.seq        = SQ_JUMP;
            cw.target     = US_DONE;
         end
         US_RD: begin
            cw.asel = AS_REQ;
         end
         US_RDCAP: begin
            cw.ld_rdata = 1'b1;
            cw.seq      = SQ_JUMP;
            cw.target   = US_DONE;
         end
         US_EX0: begin
            cw.asel   = AS_PC;
            cw.seq    = SQ_HALT;
            cw.target = US_DONE;
         end
         US_EX1: begin
            cw.ld_opc = 1'b1;
            cw.asel   = AS_PC1;
         end
         US_EX2: begin
            cw.ld_opnd = 1'b1;
         end
         US_EX3: begin
            cw.asel       = AS_OPND;
            cw.mem_wr_sta = 1'b1;
         end
         US_EX4: begin
            cw.exec   = 1'b1;
            cw.seq    = SQ_JUMP;
            cw.target = US_DONE;
         end
         US_RST: begin
            cw.clr_cpu = 1'b1;
         end
         US_DONE: begin
            cw.emit   = 1'b1;
            cw.seq    = SQ_OUT;
            cw.target = US_IDLE;
         end
         default: begin
            cw.seq    = SQ_JUMP;
            cw.target = US_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== src/accu_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module accu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/accu_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on accu_pkg.
module accu_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  accu_pkg::seq_status_type status,
   output accu_pkg::ucode_type      cw
);
   import accu_pkg::*;

   ustep_type upc_ff;
   ustep_type upc_in;
   ustep_type dispatch;

   assign cw = ucode(upc_ff);

   always_comb begin
      unique case (status.cmd)
         CMD_WRITE: dispatch = US_WR;
         CMD_READ:  dispatch = US_RD;
         CMD_EXEC:  dispatch = US_EX0;
         CMD_RESET: dispatch = US_RST;
         default:   dispatch = US_IDLE;
      endcase
   end

   always_comb begin
      upc_in = upc_ff;
      case (cw.seq)
         SQ_NEXT: upc_in = upc_ff + 4'd1;
         SQ_JUMP: upc_in = cw.target;
         SQ_CMD:  upc_in = status.req_fire ? dispatch : upc_ff;
         SQ_HALT: upc_in = status.halted ? cw.target : upc_ff + 4'd1;
         SQ_OUT:  upc_in = status.out_free ? cw.target : upc_ff;
         default: upc_in = US_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= US_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== src/accumulator_cpu_8bit.sv =====
// Top level of the 8-bit accumulator CPU: datapath, memory and result register.
// Depends on accu_pkg, accu_seq and accu_ram.
//
// Use: one request per transfer on req_* (command, address, write_value);
// each request gives exactly one result transfer on rsp_* carrying the read
// byte (zero unless the command was a read), PC, accumulator, N, Z and halt.
// Requests are taken one at a time; a microcoded sequencer steps a plain
// datapath around one 256-byte RAM port with registered read.
// Execute steps: opcode fetch, operand fetch, data read or store, update;
// an execute while halted skips straight to the result. The next request is
// taken in the cycle after the result register is loaded.
// The result register holds while rsp_ready is low; the sequencer waits in
// its final step until the register is free, and req_ready stays low.
// Reset clears PC, accumulator, halt flag and the per-byte valid bits, so
// all memory reads as zero until written; there is no clearing pass.
module accumulator_cpu_8bit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  accu_pkg::cmd_type                   req_command,
   input  logic [accu_pkg::ADDR_W-1:0]         req_address,
   input  logic [accu_pkg::DATA_W-1:0]         req_write_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [accu_pkg::DATA_W-1:0]         rsp_read_data,
   output logic [accu_pkg::ADDR_W-1:0]         rsp_program_counter,
   output logic [accu_pkg::DATA_W-1:0]         rsp_accumulator_value,
   output logic                                rsp_negative_flag,
   output logic                                rsp_zero_flag,
   output logic                                rsp_halted
);
   import accu_pkg::*;

   ucode_type      cw;
   seq_status_type status;

   cmd_type             cmd_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [DATA_W-1:0]   wval_ff;
   opcode_type          opc_ff;
   logic [ADDR_W-1:0]   opnd_ff;
   logic [DATA_W-1:0]   rdata_ff;

   logic [ADDR_W-1:0]   pc_ff, pc_in;
   logic [DATA_W-1:0]   acc_ff, acc_in;
   logic                halt_ff, halt_in;

   logic [MEM_DEPTH-1:0] valid_ff;
   logic                 vq_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_rdata_ff;
   logic [ADDR_W-1:0]   rsp_pc_ff;
   logic [DATA_W-1:0]   rsp_acc_ff;
   logic                rsp_halt_ff;

   logic                req_fire;
   logic                out_free;
   logic                emit_fire;
   logic [ADDR_W-1:0]   pc_inc1, pc_inc2;
   logic [ADDR_W-1:0]   mem_addr;
   logic                mem_we;
   logic [DATA_W-1:0]   mem_wdata;
   logic [DATA_W-1:0]   ram_q;
   logic [DATA_W-1:0]   mem_q;

   assign req_ready = cw.take_req;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_fire = cw.emit && out_free;

   assign status.req_fire = req_fire;
   assign status.cmd      = req_command;
   assign status.halted   = halt_ff;
   assign status.out_free = out_free;

   accu_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   assign pc_inc1 = pc_ff + ADDR_W'(1);
   assign pc_inc2 = pc_ff + ADDR_W'(2);

   always_comb begin
      unique case (cw.asel)
         AS_REQ:  mem_addr = addr_ff;
         AS_PC:   mem_addr = pc_ff;
         AS_PC1:  mem_addr = pc_inc1;
         AS_OPND: mem_addr = opnd_ff;
         default: mem_addr = addr_ff;
      endcase
   end

   assign mem_we    = cw.mem_wr_req || (cw.mem_wr_sta && (opc_ff == OP_STA));
   assign mem_wdata = cw.mem_wr_req ? wval_ff : acc_ff;

   accu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_addr),
      .wr_data (mem_wdata),
      .rd_addr (mem_addr),
      .rd_data (ram_q)
   );

   // Bytes never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         vq_ff    <= 1'b0;
      end else begin
         if (mem_we) begin
            valid_ff[mem_addr] <= 1'b1;
         end
         vq_ff <= valid_ff[mem_addr];
      end
   end

   assign mem_q = vq_ff ? ram_q : '0;

   // Instruction update, applied in the last execute step.
   always_comb begin
      pc_in   = pc_inc1;
      acc_in  = acc_ff;
      halt_in = halt_ff;
      case (opc_ff)
         OP_STA: pc_in = pc_inc2;
         OP_LDA: begin
            acc_in = mem_q;
            pc_in  = pc_inc2;
         end
         OP_ADD: begin
            acc_in = acc_ff + mem_q;
            pc_in  = pc_inc2;
         end
         OP_OR: begin
            acc_in = acc_ff | mem_q;
            pc_in  = pc_inc2;
         end
         OP_AND: begin
            acc_in = acc_ff & mem_q;
            pc_in  = pc_inc2;
         end
         OP_NOT:  acc_in = ~acc_ff;
         OP_JMP:  pc_in = opnd_ff;
         OP_JN:   pc_in = acc_ff[DATA_W-1] ? opnd_ff : pc_inc2;
         OP_JZ:   pc_in = (acc_ff == '0) ? opnd_ff : pc_inc2;
         OP_HLT:  halt_in = 1'b1;
         default: pc_in = pc_inc1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         acc_ff  <= '0;
         halt_ff <= 1'b0;
      end else if (cw.clr_cpu) begin
         pc_ff   <= '0;
         acc_ff  <= '0;
         halt_ff <= 1'b0;
      end else if (cw.exec) begin
         pc_ff   <= pc_in;
         acc_ff  <= acc_in;
         halt_ff <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff  <= req_command;
         addr_ff <= req_address;
         wval_ff <= req_write_value;
      end
      if (cw.ld_opc) begin
         opc_ff <= mem_q[DATA_W-1 -: 4];
      end
      if (cw.ld_opnd) begin
         opnd_ff <= mem_q;
      end
      if (cw.ld_rdata) begin
         rdata_ff <= mem_q;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_rdata_ff <= (cmd_ff == CMD_READ) ? rdata_ff : '0;
         rsp_pc_ff    <= pc_ff;
         rsp_acc_ff   <= acc_ff;
         rsp_halt_ff  <= halt_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_read_data         = rsp_rdata_ff;
   assign rsp_program_counter   = rsp_pc_ff;
   assign rsp_accumulator_value = rsp_acc_ff;
   assign rsp_negative_flag     = rsp_acc_ff[DATA_W-1];
   assign rsp_zero_flag         = (rsp_acc_ff == '0);
   assign rsp_halted            = rsp_halt_ff;

endmodule

// ===== src/accu_chk.sv =====
// Port-level checker for the accumulator CPU, bound to the top level.
// Depends on accu_pkg and accumulator_cpu_8bit_macros.svh.
`include "accumulator_cpu_8bit_macros.svh"

module accu_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input accu_pkg::cmd_type           req_command,
   input logic [accu_pkg::ADDR_W-1:0] req_address,
   input logic [accu_pkg::DATA_W-1:0] req_write_value,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [accu_pkg::DATA_W-1:0] rsp_read_data,
   input logic [accu_pkg::ADDR_W-1:0] rsp_program_counter,
   input logic [accu_pkg::DATA_W-1:0] rsp_accumulator_value,
   input logic                        rsp_negative_flag,
   input logic                        rsp_zero_flag,
   input logic                        rsp_halted
);

   // A stalled result must hold.
   `ACCU_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid,
                    "result dropped while stalled")

   // One request at a time: no transfer directly after a transfer.
   `ACCU_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready,
                    "request taken while busy")

   `ACCU_ASSERT_NOW(a_neg_flag, clock, reset, rsp_valid,
                    rsp_negative_flag == rsp_accumulator_value[accu_pkg::DATA_W-1],
                    "negative flag disagrees with accumulator")

   `ACCU_ASSERT_NOW(a_zero_flag, clock, reset, rsp_valid,
                    rsp_zero_flag == (rsp_accumulator_value == '0),
                    "zero flag disagrees with accumulator")

endmodule

bind accumulator_cpu_8bit accu_chk u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench of the 8-bit accumulator CPU: a driver and a monitor on
// the request and result channels, checked against a predictor of the machine.
// Depends on accu_pkg and accumulator_cpu_8bit.
`timescale 1ns / 1ps

module tb;
   import accu_pkg::*;

   localparam opcode_type OP_UNDEF = 4'h7;
   localparam int STALL_LIMIT      = 2000;
   localparam int PHASE_ITEMS      = 95;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] addr;
      logic [7:0] wval;
   } cpu_request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] pc;
      logic [7:0] acc;
      logic       neg;
      logic       zero;
      logic       halt;
   } cpu_view_type;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   cmd_type             req_command     = CMD_WRITE;
   logic [ADDR_W-1:0]   req_address     = '0;
   logic [DATA_W-1:0]   req_write_value = '0;
   logic                rsp_ready       = 1'b0;
   logic                req_ready;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_read_data;
   logic [ADDR_W-1:0]   rsp_program_counter;
   logic [DATA_W-1:0]   rsp_accumulator_value;
   logic                rsp_negative_flag;
   logic                rsp_zero_flag;
   logic                rsp_halted;

   // Predicted machine state
   logic [7:0] mem_image [0:MEM_DEPTH-1];
   logic [7:0] cpu_pc     = '0;
   logic [7:0] cpu_acc    = '0;
   logic       cpu_halted = 1'b0;

   cpu_request_type request_backlog[$];
   cpu_view_type    predicted_views[$];
   int              items_queued   = 0;
   int              responses_seen = 0;
   int              fault_count    = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              quiet_cycles   = 0;

   accumulator_cpu_8bit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_command           (req_command),
      .req_address           (req_address),
      .req_write_value       (req_write_value),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_read_data         (rsp_read_data),
      .rsp_program_counter   (rsp_program_counter),
      .rsp_accumulator_value (rsp_accumulator_value),
      .rsp_negative_flag     (rsp_negative_flag),
      .rsp_zero_flag         (rsp_zero_flag),
      .rsp_halted            (rsp_halted)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Advance the predicted machine by one command and return the view it reports.
   function automatic cpu_view_type apply_request(input cpu_request_type rq);
      cpu_view_type v;
      opcode_type   op;
      logic [7:0]   opnd;
      v = '0;
      case (rq.cmd)
         CMD_WRITE: mem_image[rq.addr] = rq.wval;
         CMD_READ:  v.read_data = mem_image[rq.addr];
         CMD_EXEC: begin
            if (!cpu_halted) begin
               op   = mem_image[cpu_pc][7:4];
               opnd = mem_image[8'(cpu_pc + 8'd1)];
               case (op)
                  OP_STA: begin
                     mem_image[opnd] = cpu_acc;
                     cpu_pc = cpu_pc + 8'd2;
                  end
                  OP_LDA: begin
                     cpu_acc = mem_image[opnd];
                     cpu_pc  = cpu_pc + 8'd2;
                  end
                  OP_ADD: begin
                     cpu_acc = cpu_acc + mem_image[opnd];
                     cpu_pc  = cpu_pc + 8'd2;
                  end
                  OP_OR: begin
                     cpu_acc = cpu_acc | mem_image[opnd];
                     cpu_pc  = cpu_pc + 8'd2;
                  end
                  OP_AND: begin
                     cpu_acc = cpu_acc & mem_image[opnd];
                     cpu_pc  = cpu_pc + 8'd2;
                  end
                  OP_NOT: begin
                     cpu_acc = ~cpu_acc;
                     cpu_pc  = cpu_pc + 8'd1;
                  end
                  OP_JMP: cpu_pc = opnd;
                  OP_JN:  cpu_pc = cpu_acc[7] ? opnd : 8'(cpu_pc + 8'd2);
                  OP_JZ:  cpu_pc = (cpu_acc == 8'd0) ? opnd : 8'(cpu_pc + 8'd2);
                  OP_HLT: begin
                     cpu_halted = 1'b1;
                     cpu_pc     = cpu_pc + 8'd1;
                  end
                  default: cpu_pc = cpu_pc + 8'd1;
               endcase
            end
         end
         default: begin
            cpu_pc     = '0;
            cpu_acc    = '0;
            cpu_halted = 1'b0;
         end
      endcase
      v.pc   = cpu_pc;
      v.acc  = cpu_acc;
      v.neg  = cpu_acc[7];
      v.zero = (cpu_acc == 8'd0);
      v.halt = cpu_halted;
      return v;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   task automatic push_request(input cmd_type c, input logic [7:0] a, input logic [7:0] v);
      request_backlog.push_back('{cmd: c, addr: a, wval: v});
      items_queued++;
   endtask

   // Load a short program with its data, then step through it with the odd read.
   task automatic push_program_burst();
      logic [7:0] base;
      logic [7:0] at;
      logic [7:0] opnd;
      opcode_type op;
      int         n_instr;
      if ($urandom_range(0, 4) != 0) push_request(CMD_RESET, rand_byte(), rand_byte());
      base = 8'h00;
      if ($urandom_range(0, 4) == 0) begin
         // place the program near the top of memory so that it runs across the wrap
         base = 8'($urandom_range(246, 255));
         push_request(CMD_WRITE, 8'h00, {OP_JMP, 4'($urandom)});
         push_request(CMD_WRITE, 8'h01, base);
      end
      repeat ($urandom_range(1, 4))
         push_request(CMD_WRITE, 8'h80 + 8'($urandom_range(0, 15)), rand_byte());
      n_instr = $urandom_range(3, 8);
      at = base;
      repeat (n_instr) begin
         op = 4'($urandom);
         if (op == OP_HLT && $urandom_range(0, 1) == 1) op = OP_LDA;
         push_request(CMD_WRITE, at, {op, 4'($urandom)});
         at++;
         if (op inside {OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_JMP, OP_JN, OP_JZ}) begin
            if (op inside {OP_JMP, OP_JN, OP_JZ})
               opnd = base + 8'($urandom_range(0, 2 * n_instr));
            else if ($urandom_range(0, 7) == 0)
               opnd = rand_byte();
            else
               opnd = 8'h80 + 8'($urandom_range(0, 15));
            push_request(CMD_WRITE, at, opnd);
            at++;
         end
      end
      repeat ($urandom_range(n_instr, 2 * n_instr + 4)) begin
         if ($urandom_range(0, 5) == 0)
            push_request(CMD_READ, 8'h80 + 8'($urandom_range(0, 15)), rand_byte());
         push_request(CMD_EXEC, rand_byte(), rand_byte());
      end
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct);
      int start;
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      start = items_queued;
      while (items_queued - start < PHASE_ITEMS) begin
         push_program_burst();
         if ($urandom_range(0, 3) == 0) begin
            repeat (8) push_request(cmd_type'($urandom_range(0, 3)), rand_byte(), rand_byte());
         end
      end
      while (responses_seen < items_queued) @(posedge clock);
   endtask

   // Driver: predict on each request transfer, then present the next item or idle.
   always @(posedge clock) begin : request_driver
      cpu_request_type nx;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_views.push_back(apply_request('{cmd: req_command, addr: req_address,
                                                      wval: req_write_value}));
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nx = request_backlog.pop_front();
               req_valid       <= 1'b1;
               req_command     <= nx.cmd;
               req_address     <= nx.addr;
               req_write_value <= nx.wval;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      cpu_view_type got;
      cpu_view_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            responses_seen++;
            got = '{read_data: rsp_read_data, pc: rsp_program_counter,
                    acc: rsp_accumulator_value, neg: rsp_negative_flag,
                    zero: rsp_zero_flag, halt: rsp_halted};
            if (predicted_views.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("unexpected result: rd=%h pc=%h acc=%h n=%b z=%b h=%b",
                           got.read_data, got.pc, got.acc, got.neg, got.zero, got.halt);
            end else begin
               want = predicted_views.pop_front();
               if (got.read_data !== want.read_data || got.pc !== want.pc ||
                   got.acc !== want.acc || got.neg !== want.neg ||
                   got.zero !== want.zero || got.halt !== want.halt) begin
                  fault_count++;
                  if (fault_count <= 10)
                     $display("mismatch: expected rd=%h pc=%h acc=%h n=%b z=%b h=%b, %s",
                              want.read_data, want.pc, want.acc, want.neg, want.zero,
                              want.halt,
                              $sformatf("got rd=%h pc=%h acc=%h n=%b z=%b h=%b",
                                        got.read_data, got.pc, got.acc, got.neg,
                                        got.zero, got.halt));
               end
            end
         end
      end
   end

   // Watchdog: give up when neither channel has moved for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < MEM_DEPTH; i++) mem_image[i] = 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed program: load with the top byte, overflow on add, unknown opcode,
      // invert, jump to 255, conditional jump whose operand wraps to address 0, halt.
      push_request(CMD_WRITE, 8'h00, {OP_LDA, 4'h1});
      push_request(CMD_WRITE, 8'h01, 8'h80);
      push_request(CMD_WRITE, 8'h02, {OP_ADD, 4'h0});
      push_request(CMD_WRITE, 8'h03, 8'h81);
      push_request(CMD_WRITE, 8'h04, {OP_UNDEF, 4'hA});
      push_request(CMD_WRITE, 8'h05, {OP_NOT, 4'h5});
      push_request(CMD_WRITE, 8'h06, {OP_JMP, 4'hC});
      push_request(CMD_WRITE, 8'h07, 8'hFF);
      push_request(CMD_WRITE, 8'hFF, {OP_JN, 4'h3});
      push_request(CMD_WRITE, 8'h21, {OP_HLT, 4'hF});
      push_request(CMD_WRITE, 8'h80, 8'hFF);
      push_request(CMD_WRITE, 8'h81, 8'h02);
      push_request(CMD_WRITE, 8'h40, 8'h00);
      push_request(CMD_READ, 8'hFF, 8'hFF);
      push_request(CMD_READ, 8'h55, 8'hAA);
      repeat (8) push_request(CMD_EXEC, 8'hFF, 8'h00);
      push_request(CMD_RESET, 8'h00, 8'hFF);
      push_request(CMD_EXEC, 8'h00, 8'h00);
      push_request(CMD_READ, 8'h81, 8'h00);

      run_phase(0, 0);
      run_phase(65, 0);
      run_phase(0, 65);
      run_phase(7, 7);

      repeat (10) @(posedge clock);
      if (fault_count == 0 && predicted_views.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
